// ===== src/dohm_pkg.sv =====
package dohm_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int MAX_SAMPLES = 1024;
	localparam int KNOWN_W     = 20;
	localparam int FULL_W      = 12;
	localparam int CNT_W       = 11;
	localparam int SUM_W       = 22;
	localparam int NUM_W       = 42;
	localparam int DP_W        = 64;
	localparam int MEAN_STEPS  = 23;
	localparam int BOUND_W     = 8;
	localparam int CFG_W       = 20;

	localparam logic [1:0] CFG_KNOWN   = 2'd0;
	localparam logic [1:0] CFG_FULL    = 2'd1;
	localparam logic [1:0] CFG_SAMPLES = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULN,
		ST_MULF,
		ST_MPREP,
		ST_MEAN,
		ST_CHECK,
		ST_QUOT,
		ST_RANGE,
		ST_X20,
		ST_DEC,
		ST_E12,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_OPEN,
		STAT_RANGE,
		STAT_ZERO
	} status_t;

	typedef struct packed {
		logic [11:0] mean_code;
		logic [31:0] resistance_ohms;
		logic [6:0]  e12_mantissa;
		logic [3:0]  e12_decade;
		logic [3:0]  first_band;
		logic [3:0]  second_band;
		logic [2:0]  multiplier_band;
		status_t     status;
	} dohm_res_t;

	function automatic logic [6:0] e12_val(input logic [3:0] i);
		case (i)
			4'd0: e12_val = 7'd10;
			4'd1: e12_val = 7'd12;
			4'd2: e12_val = 7'd15;
			4'd3: e12_val = 7'd18;
			4'd4: e12_val = 7'd22;
			4'd5: e12_val = 7'd27;
			4'd6: e12_val = 7'd33;
			4'd7: e12_val = 7'd39;
			4'd8: e12_val = 7'd47;
			4'd9: e12_val = 7'd56;
			4'd10: e12_val = 7'd68;
			default: e12_val = 7'd82;
		endcase
	endfunction

	// sum of neighboring e12 values, the midpoint doubled
	function automatic logic [BOUND_W-1:0] e12_bound(input logic [3:0] i);
		case (i)
			4'd0: e12_bound = 8'd22;
			4'd1: e12_bound = 8'd27;
			4'd2: e12_bound = 8'd33;
			4'd3: e12_bound = 8'd40;
			4'd4: e12_bound = 8'd49;
			4'd5: e12_bound = 8'd60;
			4'd6: e12_bound = 8'd72;
			4'd7: e12_bound = 8'd86;
			4'd8: e12_bound = 8'd103;
			4'd9: e12_bound = 8'd124;
			default: e12_bound = 8'd150;
		endcase
	endfunction

	function automatic logic [3:0] e12_tens(input logic [3:0] i);
		case (i)
			4'd0, 4'd1, 4'd2, 4'd3: e12_tens = 4'd1;
			4'd4, 4'd5: e12_tens = 4'd2;
			4'd6, 4'd7: e12_tens = 4'd3;
			4'd8: e12_tens = 4'd4;
			4'd9: e12_tens = 4'd5;
			4'd10: e12_tens = 4'd6;
			default: e12_tens = 4'd8;
		endcase
	endfunction

	function automatic logic [3:0] e12_ones(input logic [3:0] i);
		case (i)
			4'd0: e12_ones = 4'd0;
			4'd1, 4'd4, 4'd11: e12_ones = 4'd2;
			4'd2: e12_ones = 4'd5;
			4'd3, 4'd10: e12_ones = 4'd8;
			4'd5, 4'd8: e12_ones = 4'd7;
			4'd6: e12_ones = 4'd3;
			4'd7: e12_ones = 4'd9;
			default: e12_ones = 4'd6;
		endcase
	endfunction

	// rounded first digit for values below ten ohms
	function automatic logic [3:0] e12_round(input logic [3:0] i);
		case (i)
			4'd0, 4'd1: e12_round = 4'd1;
			4'd2, 4'd3, 4'd4: e12_round = 4'd2;
			4'd5, 4'd6: e12_round = 4'd3;
			4'd7: e12_round = 4'd4;
			4'd8: e12_round = 4'd5;
			4'd9: e12_round = 4'd6;
			4'd10: e12_round = 4'd7;
			default: e12_round = 4'd8;
		endcase
	endfunction

	function automatic logic [DP_W-1:0] pow10(input logic [3:0] k);
		case (k)
			4'd0: pow10 = 64'd1;
			4'd1: pow10 = 64'd10;
			4'd2: pow10 = 64'd100;
			4'd3: pow10 = 64'd1000;
			4'd4: pow10 = 64'd10000;
			4'd5: pow10 = 64'd100000;
			4'd6: pow10 = 64'd1000000;
			4'd7: pow10 = 64'd10000000;
			4'd8: pow10 = 64'd100000000;
			4'd9: pow10 = 64'd1000000000;
			default: pow10 = 64'd10000000000;
		endcase
	endfunction

endpackage

// ===== src/dohm_in_if.sv =====
interface dohm_in_if;
	import dohm_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== src/dohm_out_if.sv =====
interface dohm_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] mean_code;
	logic [31:0] resistance_ohms;
	logic [6:0]  e12_mantissa;
	logic [3:0]  e12_decade;
	logic [3:0]  first_band;
	logic [3:0]  second_band;
	logic [2:0]  multiplier_band;
	logic [1:0]  status;
	modport source (output valid, output mean_code, output resistance_ohms,
		output e12_mantissa, output e12_decade, output first_band,
		output second_band, output multiplier_band, output status, input ready);
	modport sink (input valid, input mean_code, input resistance_ohms,
		input e12_mantissa, input e12_decade, input first_band,
		input second_band, input multiplier_band, input status, output ready);
endinterface

// ===== src/dohm_alu.sv =====
module dohm_alu import dohm_pkg::*; (
	input  logic [DP_W-1:0] a,
	input  logic [DP_W-1:0] b,
	input  logic            sub,
	output logic [DP_W-1:0] res,
	output logic            ge
);
	logic [DP_W:0] t;

	assign t   = {1'b0, a} + {1'b0, b ^ {DP_W{sub}}} + (DP_W+1)'(sub);
	assign res = t[DP_W-1:0];
	// carry out of a subtract means a >= b
	assign ge  = t[DP_W];
endmodule

// ===== src/dohm_calc.sv =====
module dohm_calc import dohm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   sum_in,
	input  logic [CNT_W-1:0]   cnt_in,
	input  logic [KNOWN_W-1:0] known_in,
	input  logic [FULL_W-1:0]  full_in,
	input  logic               take,
	output logic               busy,
	output logic               done,
	output dohm_res_t          res
);
	state_t state_q, state_d;

	logic [DP_W-1:0]    acc_q, mc_q, rem_q, dvd_q, ds_q, x_q;
	logic [KNOWN_W-1:0] mpl_q;
	logic [5:0]         bit_q;
	logic [SUM_W-1:0]   sum_q, ft_q, den_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FULL_W-1:0]  full_q;
	logic [NUM_W-1:0]   num_q, q_q;
	logic [3:0]         dec_q, idx_q, fin_idx;
	logic               ph_q;
	dohm_res_t          res_q;

	logic [DP_W-1:0] alu_a, alu_b, alu_res, mul_next, div_t, dvd_next;
	logic            alu_sub, alu_ge, adv, open_c;

	dohm_alu u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .res(alu_res), .ge(alu_ge));

	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_FINISH);
	assign res      = res_q;
	assign div_t    = {rem_q[DP_W-2:0], dvd_q[DP_W-1]};
	assign dvd_next = {dvd_q[DP_W-2:0], alu_ge};
	assign mul_next = mpl_q[0] ? alu_res : acc_q;
	assign adv      = !alu_ge;
	assign fin_idx  = idx_q + 4'(adv);
	assign open_c   = !(alu_ge && (alu_res != '0));

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_MULN, ST_MULF: begin
				alu_a = acc_q;
				alu_b = mc_q;
			end
			ST_MPREP: begin
				alu_a = DP_W'(sum_q);
				alu_b = DP_W'(cnt_q >> 1);
			end
			ST_MEAN: begin
				alu_a   = div_t;
				alu_b   = DP_W'(cnt_q);
				alu_sub = 1'b1;
			end
			ST_CHECK: begin
				alu_a   = DP_W'(ft_q);
				alu_b   = DP_W'(sum_q);
				alu_sub = 1'b1;
			end
			ST_QUOT: begin
				alu_a   = div_t;
				alu_b   = DP_W'(den_q);
				alu_sub = 1'b1;
			end
			ST_RANGE: begin
				alu_a   = DP_W'(q_q);
				alu_b   = pow10(4'd10);
				alu_sub = 1'b1;
			end
			ST_X20: begin
				alu_a = DP_W'(num_q) << 4;
				alu_b = DP_W'(num_q) << 2;
			end
			ST_DEC: begin
				if (!ph_q) begin
					alu_a   = DP_W'(q_q);
					alu_b   = pow10(dec_q + 4'd1);
					alu_sub = 1'b1;
				end else begin
					alu_a = ds_q << 3;
					alu_b = ds_q << 1;
				end
			end
			ST_E12: begin
				alu_a = acc_q;
				if (bit_q == 6'(BOUND_W)) begin
					alu_b   = x_q;
					alu_sub = 1'b1;
				end else begin
					alu_b = mc_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_MULN;
			ST_MULN: if (bit_q == 6'(KNOWN_W - 1)) state_d = ST_MULF;
			ST_MULF: if (bit_q == 6'(FULL_W - 1)) state_d = ST_MPREP;
			ST_MPREP: state_d = ST_MEAN;
			ST_MEAN: if (bit_q == 6'(MEAN_STEPS - 1)) state_d = ST_CHECK;
			ST_CHECK: begin
				if (sum_q == '0 || open_c) state_d = ST_FINISH;
				else state_d = ST_QUOT;
			end
			ST_QUOT: if (bit_q == 6'(NUM_W - 1)) state_d = ST_RANGE;
			ST_RANGE: begin
				if (alu_ge || q_q == '0) state_d = ST_FINISH;
				else state_d = ST_X20;
			end
			ST_X20: state_d = ST_DEC;
			ST_DEC: if (!ph_q && !(alu_ge && dec_q < 4'd9)) state_d = ST_E12;
			ST_E12: begin
				if (bit_q == 6'(BOUND_W) && !(adv && idx_q < 4'd10)) state_d = ST_FINISH;
			end
			ST_FINISH: if (take) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					bit_q <= '0;
					ph_q  <= 1'b0;
				end
				ST_MULN, ST_MULF, ST_MEAN, ST_QUOT: begin
					if (state_d != state_q) bit_q <= '0;
					else bit_q <= bit_q + 6'd1;
				end
				ST_MPREP, ST_CHECK: bit_q <= '0;
				ST_DEC: begin
					ph_q  <= !ph_q && alu_ge && dec_q < 4'd9;
					bit_q <= '0;
				end
				ST_E12: begin
					if (bit_q == 6'(BOUND_W)) bit_q <= '0;
					else bit_q <= bit_q + 6'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					sum_q  <= sum_in;
					cnt_q  <= cnt_in;
					full_q <= full_in;
					mpl_q  <= known_in;
					mc_q   <= DP_W'(sum_in);
					acc_q  <= '0;
					res_q  <= '{default: '0, status: STAT_OK};
				end
			end
			ST_MULN: begin
				acc_q <= mul_next;
				mpl_q <= mpl_q >> 1;
				mc_q  <= mc_q << 1;
				if (bit_q == 6'(KNOWN_W - 1)) begin
					num_q <= mul_next[NUM_W-1:0];
					acc_q <= '0;
					mc_q  <= DP_W'(cnt_q);
					mpl_q <= KNOWN_W'(full_q);
				end
			end
			ST_MULF: begin
				acc_q <= mul_next;
				mpl_q <= mpl_q >> 1;
				mc_q  <= mc_q << 1;
				if (bit_q == 6'(FULL_W - 1)) ft_q <= mul_next[SUM_W-1:0];
			end
			ST_MPREP: begin
				dvd_q <= {alu_res[MEAN_STEPS-1:0], (DP_W-MEAN_STEPS)'(0)};
				rem_q <= '0;
			end
			ST_MEAN: begin
				rem_q <= alu_ge ? alu_res : div_t;
				dvd_q <= dvd_next;
				if (bit_q == 6'(MEAN_STEPS - 1)) res_q.mean_code <= dvd_next[11:0];
			end
			ST_CHECK: begin
				den_q <= alu_res[SUM_W-1:0];
				rem_q <= '0;
				dvd_q <= {num_q, (DP_W-NUM_W)'(0)};
				if (sum_q == '0) begin
					res_q.status    <= STAT_ZERO;
					res_q.mean_code <= '0;
				end else if (open_c) begin
					res_q.status          <= STAT_OPEN;
					res_q.resistance_ohms <= '1;
				end
			end
			ST_QUOT: begin
				rem_q <= alu_ge ? alu_res : div_t;
				dvd_q <= dvd_next;
				if (bit_q == 6'(NUM_W - 1)) q_q <= dvd_next[NUM_W-1:0];
			end
			ST_RANGE: begin
				if (alu_ge) begin
					res_q.status          <= STAT_OPEN;
					res_q.resistance_ohms <= '1;
				end else begin
					res_q.resistance_ohms <= (q_q[NUM_W-1:32] != '0) ? '1 : q_q[31:0];
					// below one ohm reads as a one ohm color code
					if (q_q == '0) res_q.second_band <= 4'd1;
				end
			end
			ST_X20: begin
				x_q   <= alu_res;
				ds_q  <= DP_W'(den_q);
				dec_q <= '0;
			end
			ST_DEC: begin
				if (ph_q) begin
					ds_q  <= alu_res;
					dec_q <= dec_q + 4'd1;
				end else begin
					idx_q <= '0;
					acc_q <= '0;
					mc_q  <= ds_q;
					mpl_q <= KNOWN_W'(e12_bound(4'd0));
				end
			end
			ST_E12: begin
				if (bit_q != 6'(BOUND_W)) begin
					acc_q <= mul_next;
					mpl_q <= mpl_q >> 1;
					mc_q  <= mc_q << 1;
				end else if (adv && idx_q < 4'd10) begin
					idx_q <= idx_q + 4'd1;
					acc_q <= '0;
					mc_q  <= ds_q;
					mpl_q <= KNOWN_W'(e12_bound(idx_q + 4'd1));
				end else begin
					res_q.e12_mantissa <= e12_val(fin_idx);
					res_q.e12_decade   <= dec_q;
					if (dec_q == 4'd0) begin
						res_q.second_band <= e12_round(fin_idx);
					end else if (dec_q <= 4'd7) begin
						res_q.first_band      <= e12_tens(fin_idx);
						res_q.second_band     <= e12_ones(fin_idx);
						res_q.multiplier_band <= 3'(dec_q - 4'd1);
					end else begin
						res_q.status <= STAT_RANGE;
					end
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== src/divider_ohmmeter_e12_color_code.sv =====
// channel  dir  payload                                   request
// adc      in   sample                                    one adc code
// result   out  mean, ohms, e12 value, bands, status      one measurement
// cfg      in   cfg_we, cfg_index, cfg_data               one register write
//
// a non-final sample is taken in one cycle; the final sample of a measurement
// starts the shared 64-bit adder sequence: two shift-add products, two
// restoring divisions, decade search and e12 midpoint products
// adc is not ready during that sequence; a held result only stalls its end
// arst_n clears the registers to their defaults and empties the accumulator
module divider_ohmmeter_e12_color_code import dohm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	dohm_in_if.sink          adc,
	dohm_out_if.source       result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	logic [KNOWN_W-1:0] known_q;
	logic [FULL_W-1:0]  full_q;
	logic [CNT_W-1:0]   avg_q, target, seen_q, seen_n;
	logic [SUM_W-1:0]   sum_q, sum_n;
	logic               ov_q, accept, last, calc_busy, calc_done, load;
	dohm_res_t          calc_res, out_q;

	always_comb begin
		target = avg_q;
		if (avg_q == '0) target = CNT_W'(1);
		if (avg_q > CNT_W'(MAX_SAMPLES)) target = CNT_W'(MAX_SAMPLES);
	end

	assign adc.ready = !calc_busy;
	assign accept    = adc.valid && adc.ready;
	assign sum_n     = sum_q + SUM_W'(adc.sample);
	assign seen_n    = seen_q + CNT_W'(1);
	assign last      = accept && (seen_n >= target);
	assign load      = calc_done && (!ov_q || result.ready);

	dohm_calc u_calc (
		.clk(clk), .arst_n(arst_n), .start(last), .sum_in(sum_n), .cnt_in(seen_n),
		.known_in(known_q), .full_in(full_q), .take(load), .busy(calc_busy),
		.done(calc_done), .res(calc_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= KNOWN_W'(10000);
			full_q  <= FULL_W'(4095);
			avg_q   <= CNT_W'(500);
			sum_q   <= '0;
			seen_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KNOWN: known_q <= cfg_data[KNOWN_W-1:0];
					CFG_FULL: full_q <= cfg_data[FULL_W-1:0];
					CFG_SAMPLES: avg_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				sum_q  <= last ? '0 : sum_n;
				seen_q <= last ? '0 : seen_n;
			end
			if (load) ov_q <= 1'b1;
			else if (result.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= calc_res;
	end

	assign result.valid           = ov_q;
	assign result.mean_code       = out_q.mean_code;
	assign result.resistance_ohms = out_q.resistance_ohms;
	assign result.e12_mantissa    = out_q.e12_mantissa;
	assign result.e12_decade      = out_q.e12_decade;
	assign result.first_band      = out_q.first_band;
	assign result.second_band     = out_q.second_band;
	assign result.multiplier_band = out_q.multiplier_band;
	assign result.status          = out_q.status;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		last |=> calc_busy) else $error("final sample did not start the sequence");

	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> calc_busy) else $error("result loaded without a finished sequence");

	a_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_q.status == STAT_ZERO) |-> (out_q.mean_code == '0 &&
		out_q.resistance_ohms == '0)) else $error("zero reading with nonzero fields");
endmodule
